// ===== rtl/hpr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hpr_pkg: shared types and constants for the histogram percentile range core
// Holds the action codes, the fixed field widths and the sequencer states.
// ============================================================================
package hpr_pkg;

    localparam int BIN_W = 32;   // width of one bin count
    localparam int IDX_W = 9;    // width of bin indexes on the ports
    localparam int PCT_W = 7;    // width of a percent field

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SUM_RD  = 14'b00000000000010,
        S_SUM_ACC = 14'b00000000000100,
        S_THR_TOP = 14'b00000000001000,
        S_THR_BOT = 14'b00000000010000,
        S_TOP_RD  = 14'b00000000100000,
        S_TOP_MUL = 14'b00000001000000,
        S_TOP_ACC = 14'b00000010000000,
        S_TOP_CHK = 14'b00000100000000,
        S_BOT_CHK = 14'b00001000000000,
        S_BOT_RD  = 14'b00010000000000,
        S_BOT_MUL = 14'b00100000000000,
        S_BOT_ACC = 14'b01000000000000,
        S_FIN     = 14'b10000000000000
    } hpr_state_t;

endpackage

// ===== rtl/hpr_bin_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hpr_bin_ram: bin count store
// One write port and one read port with registered read data.
// ============================================================================
module hpr_bin_ram
    import hpr_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [BIN_W-1:0]           wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [BIN_W-1:0]           rd_data
);

    logic [BIN_W-1:0] mem [DEPTH];
    logic [BIN_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/histogram_percentile_range_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// histogram_percentile_range_core: percentile bin range of a stored histogram
// Stores bin counts and answers percentile range queries by scanning them.
// ============================================================================
// A bin write (action 0) is stored directly and bin writes may follow back
// to back; writes with bin_index 0 or above NUM_BINS are dropped. A query
// (action 1) holds in_stall high while one sequencer walks the store through
// its single read port, with one adder and one multiplier shared by all
// steps. With nb the bins in use (clamped to 1..NUM_BINS), a query reads and
// totals each of the nb bins, forms the top and bottom thresholds, then walks
// down from bin nb, for each bin visited reading it, scaling it by 100,
// accumulating and comparing, first against the top threshold and then below
// it against the bottom one, and at last loads the result. A zero total skips
// the scans. A finished word waits in the output register, so the next item
// is taken while it is still stalled. The bin store is undefined after reset;
// a query over a bin never written returns an undefined range. The user must
// write bins_in_use through cfg_valid/cfg_ready only while no query is in
// flight; the block itself does not enforce it. bins_in_use resets to 256.
// ============================================================================
module histogram_percentile_range_core
    import hpr_pkg::*;
#(
    parameter int NUM_BINS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [IDX_W-1:0]    bin_index,
    input  logic [BIN_W-1:0]    bin_count,
    input  logic [PCT_W-1:0]    top_percent,
    input  logic [PCT_W-1:0]    bottom_percent,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [IDX_W-1:0]    low_bin,
    output logic [IDX_W-1:0]    high_bin,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int CNT_W  = $clog2(NUM_BINS + 1);   // holds 0..NUM_BINS
    localparam int TOT_W  = BIN_W + ADDR_W;         // sum of all bins
    localparam int ACC_W  = TOT_W + PCT_W;          // sum scaled by a percent

    localparam logic [IDX_W-1:0] BINS_RESET = 9'd256;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    hpr_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   b_reg, b_next;          // current bin index
    logic [CNT_W-1:0]   nb_reg, nb_next;        // bins in use for this query
    logic [CNT_W-1:0]   yh_reg, yh_next;
    logic [CNT_W-1:0]   yl_reg, yl_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;      // total, then cum*100
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [ACC_W-1:0]   thr_top_reg, thr_top_next;
    logic [ACC_W-1:0]   thr_bot_reg, thr_bot_next;
    logic [ACC_W-1:0]   prod_reg, prod_next;
    logic [PCT_W-1:0]   ptop_reg, ptop_next;
    logic [PCT_W-1:0]   pbot_reg, pbot_next;
    logic [IDX_W-1:0]   bins_reg, bins_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   low_bin_reg, low_bin_next;
    logic [IDX_W-1:0]   high_bin_reg, high_bin_next;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    logic in_accept;
    logic out_accept;
    logic wr_ok;
    logic mem_wr_en;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign cfg_ready  = 1'b1;

    // Drop writes outside 1..NUM_BINS.
    assign wr_ok = (bin_index != '0) && (32'(bin_index) <= 32'(NUM_BINS));
    assign mem_wr_en = in_accept && (action == ACT_WRITE) && wr_ok;

    // ------------------------------------------------------------------------
    // Bin store
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BIN_W-1:0]  rd_data;

    assign wr_addr = ADDR_W'(32'(bin_index) - 32'd1);

    // Bin b lives at address b-1; the downward scan reads bin b-1.
    always_comb
    begin
        if (state_reg == S_BOT_RD)
        begin
            rd_addr = ADDR_W'(b_reg - CNT_W'(2));
        end
        else
        begin
            rd_addr = ADDR_W'(b_reg - CNT_W'(1));
        end
    end

    hpr_bin_ram #(
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (bin_count),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // Shared arithmetic: one multiplier, one adder, one comparator
    // ------------------------------------------------------------------------
    logic [TOT_W-1:0] mul_a;
    logic [PCT_W-1:0] mul_b;
    logic [ACC_W-1:0] mul_p;
    logic [ACC_W-1:0] add_b;
    logic [ACC_W-1:0] add_s;
    logic [ACC_W-1:0] cmp_thr;
    logic             reached;

    always_comb
    begin
        case (state_reg)
            S_THR_TOP:
            begin
                mul_a = acc_reg[TOT_W-1:0];
                mul_b = ptop_reg;
            end
            S_THR_BOT:
            begin
                mul_a = total_reg;
                mul_b = pbot_reg;
            end
            default:
            begin
                mul_a = TOT_W'(rd_data);
                mul_b = PCT_SCALE;
            end
        endcase
    end

    assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

    // Totaling adds raw counts, the scans add counts scaled by 100.
    assign add_b = (state_reg == S_SUM_ACC) ? ACC_W'(rd_data) : prod_reg;
    assign add_s = acc_reg + add_b;

    assign cmp_thr = (state_reg == S_TOP_CHK) ? thr_top_reg : thr_bot_reg;
    assign reached = (acc_reg >= cmp_thr);

    // Clamp bins_in_use to 1..NUM_BINS.
    logic [CNT_W-1:0] nb_clamped;

    always_comb
    begin
        if (bins_reg == '0)
        begin
            nb_clamped = CNT_W'(1);
        end
        else if (32'(bins_reg) > 32'(NUM_BINS))
        begin
            nb_clamped = CNT_W'(NUM_BINS);
        end
        else
        begin
            nb_clamped = CNT_W'(bins_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        b_next         = b_reg;
        nb_next        = nb_reg;
        yh_next        = yh_reg;
        yl_next        = yl_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        thr_top_next   = thr_top_reg;
        thr_bot_next   = thr_bot_reg;
        prod_next      = prod_reg;
        ptop_next      = ptop_reg;
        pbot_next      = pbot_reg;
        bins_next      = bins_reg;
        out_valid_next = out_valid_reg && !out_accept;
        low_bin_next   = low_bin_reg;
        high_bin_next  = high_bin_reg;

        if (cfg_valid && cfg_ready)
        begin
            bins_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_QUERY))
                begin
                    nb_next    = nb_clamped;
                    ptop_next  = top_percent;
                    pbot_next  = bottom_percent;
                    b_next     = CNT_W'(1);
                    acc_next   = '0;
                    state_next = S_SUM_RD;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                acc_next = add_s;
                if (b_reg == nb_reg)
                begin
                    state_next = S_THR_TOP;
                end
                else
                begin
                    b_next     = b_reg + CNT_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_THR_TOP:
            begin
                total_next   = acc_reg[TOT_W-1:0];
                thr_top_next = mul_p;
                yh_next      = nb_reg;
                yl_next      = nb_reg;
                b_next       = nb_reg;
                if (acc_reg == '0)
                begin
                    // Empty histogram: whole range.
                    yl_next    = CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_THR_BOT;
                end
            end
            S_THR_BOT:
            begin
                thr_bot_next = mul_p;
                acc_next     = '0;
                state_next   = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                state_next = S_TOP_MUL;
            end
            S_TOP_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_TOP_ACC;
            end
            S_TOP_ACC:
            begin
                acc_next   = add_s;
                state_next = S_TOP_CHK;
            end
            S_TOP_CHK:
            begin
                if (reached)
                begin
                    yh_next    = b_reg;
                    state_next = S_BOT_CHK;
                end
                else if (b_reg == CNT_W'(1))
                begin
                    // Top edge never met: resume the low scan at bins in use.
                    b_next     = nb_reg;
                    state_next = S_BOT_CHK;
                end
                else
                begin
                    b_next     = b_reg - CNT_W'(1);
                    state_next = S_TOP_RD;
                end
            end
            S_BOT_CHK:
            begin
                if (reached)
                begin
                    yl_next    = b_reg;
                    state_next = S_FIN;
                end
                else if (b_reg == CNT_W'(1))
                begin
                    // Only the underflow bin (zero) is left.
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_BOT_RD;
                end
            end
            S_BOT_RD:
            begin
                state_next = S_BOT_MUL;
            end
            S_BOT_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_BOT_ACC;
            end
            S_BOT_ACC:
            begin
                acc_next   = add_s;
                b_next     = b_reg - CNT_W'(1);
                state_next = S_BOT_CHK;
            end
            S_FIN:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (yl_reg > yh_reg)
                    begin
                        low_bin_next  = IDX_W'(yh_reg);
                        high_bin_next = IDX_W'(yl_reg);
                    end
                    else
                    begin
                        low_bin_next  = IDX_W'(yl_reg);
                        high_bin_next = IDX_W'(yh_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bins_reg      <= BINS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bins_reg      <= bins_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        nb_reg       <= nb_next;
        yh_reg       <= yh_next;
        yl_reg       <= yl_next;
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        thr_top_reg  <= thr_top_next;
        thr_bot_reg  <= thr_bot_next;
        prod_reg     <= prod_next;
        ptop_reg     <= ptop_next;
        pbot_reg     <= pbot_next;
        low_bin_reg  <= low_bin_next;
        high_bin_reg <= high_bin_next;
    end

    assign out_valid = out_valid_reg;
    assign low_bin   = low_bin_reg;
    assign high_bin  = high_bin_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (action == ACT_QUERY) |=> state_reg == S_SUM_RD)
        else $error("accepted query did not start the totaling scan");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (action == ACT_WRITE) |=> state_reg == S_IDLE)
        else $error("bin write left the idle state");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result word appeared outside the final step");

    a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (low_bin_reg <= high_bin_reg) && (low_bin_reg != '0))
        else $error("result range is out of order or starts at bin zero");

endmodule
